// ----- design/clns_pkg.sv -----
package clns_pkg;

  // Item classes after decode
  typedef enum logic [1:0] {
    K_TICK = 2'd0,
    K_BYTE = 2'd1,
    K_INIT = 2'd2
  } kind_t;

  // Input mode codes
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_INIT   = 2'd2;
  localparam logic [1:0] MODE_CURSOR = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_POWER_ON_WAIT = 3'd0;
  localparam logic [2:0] REG_INIT_STEP_WAIT = 3'd1;
  localparam logic [2:0] REG_INIT_CMD_WAIT = 3'd2;
  localparam logic [2:0] REG_CLEAR_WAIT = 3'd3;
  localparam logic [2:0] REG_CURSOR_WAIT = 3'd4;

  // Reset values of the wait registers
  localparam logic [15:0] RST_POWER_ON_WAIT = 16'd4200;
  localparam logic [15:0] RST_INIT_STEP_WAIT = 16'd120;
  localparam logic [15:0] RST_INIT_CMD_WAIT = 16'd50;
  localparam logic [15:0] RST_CLEAR_WAIT = 16'd2000;
  localparam logic [15:0] RST_CURSOR_WAIT = 16'd50;

  // Cursor addressing
  localparam logic [7:0] DDRAM_ROW0 = 8'h80;
  localparam logic [7:0] DDRAM_ROW1 = 8'hC0;
  localparam logic [5:0] MAX_COLUMN = 6'd39;

  // Init sequence steps: raw pulses first, then byte commands
  localparam logic [3:0] INIT_FIRST = 4'd1;
  localparam logic [3:0] INIT_RAW_LAST = 4'd4;
  localparam logic [3:0] INIT_CMD_FIRST = 4'd5;
  localparam logic [3:0] INIT_LAST = 4'd9;
  localparam logic [3:0] RAW_NIB_WAKE = 4'h3;
  localparam logic [3:0] RAW_NIB_4BIT = 4'h2;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  // One decoded beat moving from front to back
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  byte_val;
    logic        rs;
    logic [15:0] delay;
  } item_t;

  // Wait settings the sequencer needs
  typedef struct packed {
    logic [15:0] power_on;
    logic [15:0] init_step;
    logic [15:0] init_cmd;
    logic [15:0] clear;
  } waits_t;

  // Init command list
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'b0010_1000;
      3'd1:    c = 8'b0000_1000;
      3'd2:    c = 8'b0000_0001;
      3'd3:    c = 8'b0000_0110;
      3'd4:    c = 8'b0000_1100;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- design/clns_front.sv -----
module clns_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic [1:0]       in_mode,
  input  logic [7:0]       in_byte_value,
  input  logic             in_register_select,
  input  logic [15:0]      in_delay_after_us,
  input  logic             in_cursor_row,
  input  logic [5:0]       in_cursor_column,
  output clns_pkg::item_t  item,
  output clns_pkg::waits_t waits
);
  import clns_pkg::*;

  logic [15:0] power_on_r, init_step_r, init_cmd_r, clear_r, cursor_r;
  logic [5:0]  col_sat;
  logic [7:0]  row_base;

  // Hold the wait registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_on_r  <= RST_POWER_ON_WAIT;
      init_step_r <= RST_INIT_STEP_WAIT;
      init_cmd_r  <= RST_INIT_CMD_WAIT;
      clear_r     <= RST_CLEAR_WAIT;
      cursor_r    <= RST_CURSOR_WAIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_POWER_ON_WAIT:  power_on_r  <= cfg_data;
        REG_INIT_STEP_WAIT: init_step_r <= cfg_data;
        REG_INIT_CMD_WAIT:  init_cmd_r  <= cfg_data;
        REG_CLEAR_WAIT:     clear_r     <= cfg_data;
        REG_CURSOR_WAIT:    cursor_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign waits = '{power_on: power_on_r, init_step: init_step_r,
                   init_cmd: init_cmd_r, clear: clear_r};

  // Saturate the column and pick the row address
  assign col_sat  = (in_cursor_column > MAX_COLUMN) ? MAX_COLUMN : in_cursor_column;
  assign row_base = in_cursor_row ? DDRAM_ROW1 : DDRAM_ROW0;

  // Classify the beat; writes and cursor moves both become byte sends
  always_comb begin
    item.kind     = K_TICK;
    item.byte_val = in_byte_value;
    item.rs       = in_register_select;
    item.delay    = in_delay_after_us;
    unique case (in_mode)
      MODE_TICK:  item.kind = K_TICK;
      MODE_WRITE: item.kind = K_BYTE;
      MODE_INIT:  item.kind = K_INIT;
      MODE_CURSOR: begin
        item.kind     = K_BYTE;
        item.byte_val = row_base + {2'b00, col_sat};
        item.rs       = 1'b0;
        item.delay    = cursor_r;
      end
      default: item.kind = K_TICK;
    endcase
  end

endmodule

// ----- design/clns_queue.sv -----
module clns_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clns_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output clns_pkg::item_t head
);
  import clns_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  // Advance pointers and count
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop) rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- design/clns_back.sv -----
module clns_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  clns_pkg::item_t  q_item,
  output logic             q_pop,
  input  clns_pkg::waits_t waits,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [3:0]       out_lcd_data_nibble,
  output logic             out_lcd_rs,
  output logic             out_lcd_e,
  output logic             out_busy_res,
  output logic             out_rejected
);
  import clns_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_SETUP = 5'b00010,
    PH_HIGH  = 5'b00100,
    PH_LOW   = 5'b01000,
    PH_WAIT  = 5'b10000
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] wait_r, wait_nxt, wait_dec;
  logic [7:0]  pend_byte_r, pend_byte_nxt;
  logic        pend_rs_r, pend_rs_nxt;
  logic [15:0] pend_delay_r, pend_delay_nxt;
  logic        second_r, second_nxt;
  logic [3:0]  init_step_r, init_step_nxt;
  logic [3:0]  pin_nib_r, pin_nib_nxt;
  logic        pin_rs_r, pin_rs_nxt;
  logic        pin_e_r, pin_e_nxt;
  logic        rej_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_rej_r, out_busy_r;

  logic        done, do_launch, byte_nib;
  logic [3:0]  step_sel, step_off;
  logic        l_raw;
  logic [7:0]  l_cmd;
  logic [15:0] l_delay;

  // Take the head beat whenever the output slot is free or draining
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  assign wait_dec = (wait_r != '0) ? wait_r - 16'd1 : '0;
  assign byte_nib = (init_step_r == '0) || (init_step_r >= INIT_CMD_FIRST);

  // Work out what an init step launches
  assign step_sel = (q_item.kind == K_INIT) ? INIT_FIRST : init_step_r + 4'd1;
  assign step_off = step_sel - INIT_CMD_FIRST;
  assign l_raw    = (step_sel >= INIT_FIRST) && (step_sel <= INIT_RAW_LAST);
  assign l_cmd    = init_cmd(step_off[2:0]);

  always_comb begin
    if (l_raw) l_delay = (step_sel == INIT_FIRST) ? waits.power_on : waits.init_step;
    else l_delay = (l_cmd == CMD_CLEAR) ? waits.clear : waits.init_cmd;
  end

  // Sequencer next state
  always_comb begin
    phase_nxt      = phase_r;
    wait_nxt       = wait_r;
    pend_byte_nxt  = pend_byte_r;
    pend_rs_nxt    = pend_rs_r;
    pend_delay_nxt = pend_delay_r;
    second_nxt     = second_r;
    init_step_nxt  = init_step_r;
    pin_nib_nxt    = pin_nib_r;
    pin_rs_nxt     = pin_rs_r;
    pin_e_nxt      = pin_e_r;
    rej_nxt        = 1'b0;
    done           = 1'b0;
    do_launch      = 1'b0;

    if (q_item.kind == K_TICK) begin
      // Advance the strobe timing by one microsecond
      unique case (phase_r)
        PH_SETUP: begin
          pin_e_nxt = 1'b1;
          phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          pin_e_nxt = 1'b0;
          phase_nxt = PH_LOW;
        end
        PH_LOW: begin
          if (pend_delay_r == '0) begin
            done = 1'b1;
          end else begin
            wait_nxt  = pend_delay_r;
            phase_nxt = PH_WAIT;
          end
        end
        PH_WAIT: begin
          wait_nxt = wait_dec;
          if (wait_dec == '0) done = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else if (phase_r != PH_IDLE) begin
      // Drop commands that arrive mid-sequence
      rej_nxt = 1'b1;
    end else if (q_item.kind == K_BYTE) begin
      init_step_nxt  = '0;
      pend_byte_nxt  = q_item.byte_val;
      pend_rs_nxt    = q_item.rs;
      second_nxt     = 1'b0;
      pin_nib_nxt    = q_item.byte_val[7:4];
      pin_rs_nxt     = q_item.rs;
      pend_delay_nxt = q_item.delay;
      pin_e_nxt      = 1'b0;
      phase_nxt      = PH_SETUP;
    end else begin
      init_step_nxt = INIT_FIRST;
      second_nxt    = 1'b0;
      do_launch     = 1'b1;
    end

    // Finish a nibble: low nibble next, next init step, or idle
    if (done) begin
      if (byte_nib && !second_r) begin
        second_nxt  = 1'b1;
        pin_nib_nxt = pend_byte_r[3:0];
        pin_rs_nxt  = pend_rs_r;
        pin_e_nxt   = 1'b0;
        phase_nxt   = PH_SETUP;
      end else begin
        second_nxt = 1'b0;
        if ((init_step_r >= INIT_FIRST) && (init_step_r < INIT_LAST)) begin
          init_step_nxt = step_sel;
          do_launch     = 1'b1;
        end else begin
          init_step_nxt = '0;
          phase_nxt     = PH_IDLE;
        end
      end
    end

    // Start an init step: raw pulses skip the setup microsecond
    if (do_launch) begin
      pend_rs_nxt    = 1'b0;
      pin_rs_nxt     = 1'b0;
      pend_delay_nxt = l_delay;
      if (l_raw) begin
        pin_nib_nxt = (step_sel == INIT_RAW_LAST) ? RAW_NIB_4BIT : RAW_NIB_WAKE;
        pin_e_nxt   = 1'b1;
        phase_nxt   = PH_HIGH;
      end else begin
        pend_byte_nxt = l_cmd;
        second_nxt    = 1'b0;
        pin_nib_nxt   = l_cmd[7:4];
        pin_e_nxt     = 1'b0;
        phase_nxt     = PH_SETUP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      wait_r       <= '0;
      pend_byte_r  <= '0;
      pend_rs_r    <= 1'b0;
      pend_delay_r <= '0;
      second_r     <= 1'b0;
      init_step_r  <= '0;
      pin_nib_r    <= '0;
      pin_rs_r     <= 1'b0;
      pin_e_r      <= 1'b0;
    end else if (q_pop) begin
      phase_r      <= phase_nxt;
      wait_r       <= wait_nxt;
      pend_byte_r  <= pend_byte_nxt;
      pend_rs_r    <= pend_rs_nxt;
      pend_delay_r <= pend_delay_nxt;
      second_r     <= second_nxt;
      init_step_r  <= init_step_nxt;
      pin_nib_r    <= pin_nib_nxt;
      pin_rs_r     <= pin_rs_nxt;
      pin_e_r      <= pin_e_nxt;
    end
  end

  // Output beat register
  assign out_valid_nxt = q_pop ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_rej_r  <= rej_nxt;
      out_busy_r <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_lcd_data_nibble = pin_nib_r;
  assign out_lcd_rs          = pin_rs_r;
  assign out_lcd_e           = pin_e_r;
  assign out_busy_res        = out_busy_r;
  assign out_rejected        = out_rej_r;

endmodule

// ----- design/char_lcd_nibble_sequencer_core.sv -----
// Character LCD 4-bit bus sequencer.
// Input channel (in_valid / in_stall): one beat per event. Mode tick stands
// for one elapsed microsecond; write sends a byte high nibble first; init plays
// the power-on sequence; cursor sends a DDRAM address with column held to 39.
// Result channel (out_valid / out_stall): exactly one beat per input beat, in
// order, carrying the pin levels after that event, the busy flag and a flag
// for a command dropped while a sequence was running.
// Configuration: cfg_we with cfg_index selects one of five 16-bit wait
// registers; write only while no beat is in flight.
// Throughput: one beat per cycle while the receiver does not stall.
// An accepted beat is written into the queue; the sequencer steps and the result
// beat is registered when the back end pops it from the queue.
// The front decodes into a short queue; when the receiver stalls, the output
// beat holds, the queue fills and in_stall rises once it is full.
// Reset loads the default waits, empties the queue, idles the sequencer with
// all pins low and drops out_valid.
module char_lcd_nibble_sequencer_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_byte_value,
  input  logic        in_register_select,
  input  logic [15:0] in_delay_after_us,
  input  logic        in_cursor_row,
  input  logic [5:0]  in_cursor_column,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_lcd_data_nibble,
  output logic        out_lcd_rs,
  output logic        out_lcd_e,
  output logic        out_busy_res,
  output logic        out_rejected
);
  import clns_pkg::*;

  item_t  dec_item, head_item;
  waits_t waits;
  logic   q_full, q_not_empty, q_pop;

  clns_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_mode           (in_mode),
    .in_byte_value     (in_byte_value),
    .in_register_select(in_register_select),
    .in_delay_after_us (in_delay_after_us),
    .in_cursor_row     (in_cursor_row),
    .in_cursor_column  (in_cursor_column),
    .item              (dec_item),
    .waits             (waits)
  );

  assign in_stall = q_full;

  clns_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !q_full),
    .push_item(dec_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (head_item)
  );

  clns_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_not_empty),
    .q_item             (head_item),
    .q_pop              (q_pop),
    .waits              (waits),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_lcd_data_nibble(out_lcd_data_nibble),
    .out_lcd_rs         (out_lcd_rs),
    .out_lcd_e          (out_lcd_e),
    .out_busy_res       (out_busy_res),
    .out_rejected       (out_rejected)
  );

endmodule

// ----- design/clns_checker.sv -----
module clns_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_stall,
  input logic out_lcd_e,
  input logic out_busy_res,
  input logic out_rejected
);

  // A stalled result beat stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped under stall");

  // A dropped command only happens while a sequence runs
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |-> out_busy_res)
    else $error("rejected beat reported while idle");

  // The strobe is only high in the middle of a nibble
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_lcd_e |-> out_busy_res)
    else $error("enable high while idle");

  // Reset empties the result slot
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_lcd_e   (out_lcd_e),
  .out_busy_res(out_busy_res),
  .out_rejected(out_rejected)
);

// ----- tb/sv/char_lcd_nibble_sequencer_core_tb.sv -----
module char_lcd_nibble_sequencer_core_tb;
  import clns_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 6;
  // Init command bytes, first command in the low byte
  localparam logic [39:0] INIT_BYTES = {8'h0C, 8'h06, 8'h01, 8'h08, 8'h28};

  typedef enum logic [2:0] {
    SEQ_IDLE  = 3'd0,
    SEQ_SETUP = 3'd1,
    SEQ_HIGH  = 3'd2,
    SEQ_LOW   = 3'd3,
    SEQ_WAIT  = 3'd4
  } seq_phase_t;

  typedef enum logic [1:0] {
    GAP_NONE = 2'd0,
    GAP_SEND = 2'd1,
    GAP_RECV = 2'd2,
    GAP_BOTH = 2'd3
  } gap_mode_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  byte_v;
    logic        rs;
    logic [15:0] delay;
    logic        row;
    logic [5:0]  col;
  } lcd_cmd_t;

  typedef struct packed {
    logic [3:0] nib;
    logic       rs;
    logic       en;
    logic       busy;
    logic       rej;
  } lcd_pins_t;

  typedef struct packed {
    seq_phase_t  ph;
    logic [15:0] wcnt;
    logic [7:0]  pbyte;
    logic        prs;
    logic [15:0] pdelay;
    logic        second;
    logic [3:0]  istep;
    logic [3:0]  pin_nib;
    logic        pin_rs;
    logic        pin_en;
  } seq_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_byte_value = '0;
  logic        in_register_select = 1'b0;
  logic [15:0] in_delay_after_us = '0;
  logic        in_cursor_row = 1'b0;
  logic [5:0]  in_cursor_column = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  out_lcd_data_nibble;
  logic        out_lcd_rs;
  logic        out_lcd_e;
  logic        out_busy_res;
  logic        out_rejected;

  // Wait registers as the block should hold them
  logic [15:0] wait_regs [0:4];
  seq_state_t  model_st;
  seq_state_t  plan_st;
  gap_mode_t   gap_mode = GAP_NONE;
  lcd_cmd_t    lcd_cmds_pending [$];
  lcd_pins_t   pins_due [$];
  logic        hold_arm = 1'b0;
  logic        hold_done = 1'b0;
  int          hold_cnt = 0;
  int          quiet_cycles = 0;
  int          mismatches = 0;
  int          beats_in = 0;
  int          results_seen = 0;
  int          rejects_seen = 0;
  int          cfg_writes = 0;
  int          settings_used = 0;

  char_lcd_nibble_sequencer_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_byte_value       (in_byte_value),
    .in_register_select  (in_register_select),
    .in_delay_after_us   (in_delay_after_us),
    .in_cursor_row       (in_cursor_row),
    .in_cursor_column    (in_cursor_column),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_lcd_data_nibble (out_lcd_data_nibble),
    .out_lcd_rs          (out_lcd_rs),
    .out_lcd_e           (out_lcd_e),
    .out_busy_res        (out_busy_res),
    .out_rejected        (out_rejected)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- sequencer predictor

  function automatic seq_state_t seq_reset_state();
    seq_state_t st;
    st = '0;
    st.ph = SEQ_IDLE;
    return st;
  endfunction

  function automatic void seq_start_nibble(inout seq_state_t st, input logic [3:0] nib,
                                           input logic rs, input logic [15:0] dly,
                                           input logic with_setup);
    st.pin_nib = nib;
    st.pin_rs = rs;
    st.pdelay = dly;
    st.pin_en = !with_setup;
    st.ph = with_setup ? SEQ_SETUP : SEQ_HIGH;
  endfunction

  function automatic void seq_begin_byte(inout seq_state_t st, input logic [7:0] b,
                                         input logic rs, input logic [15:0] dly);
    st.pbyte = b;
    st.prs = rs;
    st.second = 1'b0;
    seq_start_nibble(st, b[7:4], rs, dly, 1'b1);
  endfunction

  // Raw wake-up pulses go out with E already high; later steps are full bytes
  function automatic void seq_init_step(inout seq_state_t st, input logic [3:0] s);
    logic [7:0]  cmd;
    logic [15:0] dly;
    if (s >= INIT_FIRST && s <= INIT_RAW_LAST) begin
      dly = (s == INIT_FIRST) ? wait_regs[REG_POWER_ON_WAIT] : wait_regs[REG_INIT_STEP_WAIT];
      st.prs = 1'b0;
      seq_start_nibble(st, (s == INIT_RAW_LAST) ? RAW_NIB_4BIT : RAW_NIB_WAKE, 1'b0, dly, 1'b0);
    end else begin
      cmd = INIT_BYTES[(s - INIT_CMD_FIRST) * 8 +: 8];
      dly = (cmd == CMD_CLEAR) ? wait_regs[REG_CLEAR_WAIT] : wait_regs[REG_INIT_CMD_WAIT];
      seq_begin_byte(st, cmd, 1'b0, dly);
    end
  endfunction

  // Move to the low nibble, the next init step, or back to idle
  function automatic void seq_nibble_done(inout seq_state_t st);
    logic byte_nib;
    byte_nib = (st.istep == 4'd0) || (st.istep >= INIT_CMD_FIRST);
    if (byte_nib && !st.second) begin
      st.second = 1'b1;
      seq_start_nibble(st, st.pbyte[3:0], st.prs, st.pdelay, 1'b1);
    end else begin
      st.second = 1'b0;
      if (st.istep >= INIT_FIRST && st.istep < INIT_LAST) begin
        st.istep = st.istep + 4'd1;
        seq_init_step(st, st.istep);
      end else begin
        st.istep = 4'd0;
        st.ph = SEQ_IDLE;
      end
    end
  endfunction

  function automatic void seq_tick(inout seq_state_t st);
    case (st.ph)
      SEQ_SETUP: begin
        st.pin_en = 1'b1;
        st.ph = SEQ_HIGH;
      end
      SEQ_HIGH: begin
        st.pin_en = 1'b0;
        st.ph = SEQ_LOW;
      end
      SEQ_LOW: begin
        if (st.pdelay == 16'd0) begin
          seq_nibble_done(st);
        end else begin
          st.wcnt = st.pdelay;
          st.ph = SEQ_WAIT;
        end
      end
      SEQ_WAIT: begin
        if (st.wcnt != 16'd0) st.wcnt = st.wcnt - 16'd1;
        if (st.wcnt == 16'd0) seq_nibble_done(st);
      end
      default: st.ph = SEQ_IDLE;
    endcase
  endfunction

  // Apply one beat and return the pin levels and status it leaves behind
  function automatic lcd_pins_t lcd_advance(inout seq_state_t st, input lcd_cmd_t c);
    lcd_pins_t  r;
    logic [5:0] col;
    logic [7:0] addr;
    r.rej = 1'b0;
    if (c.mode == MODE_TICK) begin
      seq_tick(st);
    end else if (st.ph != SEQ_IDLE) begin
      r.rej = 1'b1;
    end else if (c.mode == MODE_WRITE) begin
      st.istep = 4'd0;
      seq_begin_byte(st, c.byte_v, c.rs, c.delay);
    end else if (c.mode == MODE_INIT) begin
      st.istep = INIT_FIRST;
      st.second = 1'b0;
      seq_init_step(st, INIT_FIRST);
    end else begin
      col = (c.col > MAX_COLUMN) ? MAX_COLUMN : c.col;
      addr = (c.row ? DDRAM_ROW1 : DDRAM_ROW0) + {2'b00, col};
      st.istep = 4'd0;
      seq_begin_byte(st, addr, 1'b0, wait_regs[REG_CURSOR_WAIT]);
    end
    r.nib = st.pin_nib;
    r.rs = st.pin_rs;
    r.en = st.pin_en;
    r.busy = (st.ph != SEQ_IDLE);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic lcd_cmd_t mk_cmd(input logic [1:0] m, input logic [7:0] b, input logic rs,
                                      input logic [15:0] d, input logic row,
                                      input logic [5:0] col);
    lcd_cmd_t c;
    c.mode = m;
    c.byte_v = b;
    c.rs = rs;
    c.delay = d;
    c.row = row;
    c.col = col;
    return c;
  endfunction

  function automatic lcd_cmd_t rand_cmd(input logic [1:0] m);
    return mk_cmd(m, 8'($urandom), 1'($urandom), 16'($urandom), 1'($urandom), 6'($urandom));
  endfunction

  function automatic int send_gap_pct(input gap_mode_t g);
    case (g)
      GAP_SEND: return 59;
      GAP_BOTH: return 7;
      default:  return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(input gap_mode_t g);
    case (g)
      GAP_RECV: return 59;
      GAP_BOTH: return 7;
      default:  return 0;
    endcase
  endfunction

  // Queue a beat and track where the sequencer will stand after it
  task automatic push_cmd(input lcd_cmd_t c);
    lcd_pins_t ignored;
    ignored = lcd_advance(plan_st, c);
    lcd_cmds_pending.push_back(c);
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(rand_cmd(MODE_TICK));
  endtask

  task automatic tick_until_idle();
    while (plan_st.ph != SEQ_IDLE) push_cmd(rand_cmd(MODE_TICK));
  endtask

  // Look between edges so that the driver and checker have both updated
  task automatic settle();
    while (lcd_cmds_pending.size() != 0 || in_valid || pins_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_wait(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    wait_regs[idx] = val;
    cfg_writes++;
  endtask

  // Drain, then load all five wait registers
  task automatic load_waits(input logic [15:0] pwr, input logic [15:0] stp,
                            input logic [15:0] cmd, input logic [15:0] clr,
                            input logic [15:0] cur);
    settle();
    set_wait(REG_POWER_ON_WAIT, pwr);
    set_wait(REG_INIT_STEP_WAIT, stp);
    set_wait(REG_INIT_CMD_WAIT, cmd);
    set_wait(REG_CLEAR_WAIT, clr);
    set_wait(REG_CURSOR_WAIT, cur);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic load_random_waits(input int hi);
    load_waits(16'($urandom_range(hi)), 16'($urandom_range(hi)), 16'($urandom_range(hi)),
               16'($urandom_range(hi)), 16'($urandom_range(hi)));
  endtask

  // Mostly complete commands played out by ticks, with stray commands mixed in while busy
  task automatic random_burst(input gap_mode_t g, input int n, input int max_delay);
    int       made;
    int       pick;
    lcd_cmd_t c;
    gap_mode = g;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(99);
      c = rand_cmd(MODE_WRITE);
      if (pick < 50) begin
        c.delay = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(max_delay));
      end else if (pick < 72) begin
        c.mode = MODE_CURSOR;
      end else if (pick < 80) begin
        c.mode = MODE_INIT;
      end else begin
        c.mode = MODE_TICK;
      end
      push_cmd(c);
      made++;
      while (plan_st.ph != SEQ_IDLE) begin
        if ($urandom_range(99) < 6) begin
          push_cmd(rand_cmd(2'($urandom_range(1, 3))));
        end else begin
          push_cmd(rand_cmd(MODE_TICK));
          made++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sender

  always @(posedge clk) begin
    lcd_cmd_t beat;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // Predict the result of the beat taken at this edge
      if (in_valid && !in_stall) begin
        beat = mk_cmd(in_mode, in_byte_value, in_register_select, in_delay_after_us,
                      in_cursor_row, in_cursor_column);
        pins_due.push_back(lcd_advance(model_st, beat));
        beats_in++;
      end
      // Hold a stalled beat; otherwise offer the next one or idle
      if (!in_valid || !in_stall) begin
        if (lcd_cmds_pending.size() != 0 && $urandom_range(99) >= send_gap_pct(gap_mode)) begin
          beat = lcd_cmds_pending.pop_front();
          in_valid <= 1'b1;
          in_mode <= beat.mode;
          in_byte_value <= beat.byte_v;
          in_register_select <= beat.rs;
          in_delay_after_us <= beat.delay;
          in_cursor_row <= beat.row;
          in_cursor_column <= beat.col;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver and checker

  always @(posedge clk) begin
    lcd_pins_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_rejected) rejects_seen++;
        if (pins_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: nib=%h rs=%b e=%b busy=%b rej=%b",
                     out_lcd_data_nibble, out_lcd_rs, out_lcd_e, out_busy_res, out_rejected);
        end else begin
          want = pins_due.pop_front();
          if (out_lcd_data_nibble !== want.nib || out_lcd_rs !== want.rs ||
              out_lcd_e !== want.en || out_busy_res !== want.busy ||
              out_rejected !== want.rej) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: want nib=%h rs=%b e=%b busy=%b rej=%b, got %h %b %b %b %b",
                       results_seen, want.nib, want.rs, want.en, want.busy, want.rej,
                       out_lcd_data_nibble, out_lcd_rs, out_lcd_e, out_busy_res, out_rejected);
          end
        end
      end
      // Long hold-off once, then random stalls
      if (hold_arm && !hold_done) begin
        out_stall <= 1'b1;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct(gap_mode));
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- run

  initial begin
    wait_regs[REG_POWER_ON_WAIT] = RST_POWER_ON_WAIT;
    wait_regs[REG_INIT_STEP_WAIT] = RST_INIT_STEP_WAIT;
    wait_regs[REG_INIT_CMD_WAIT] = RST_INIT_CMD_WAIT;
    wait_regs[REG_CLEAR_WAIT] = RST_CLEAR_WAIT;
    wait_regs[REG_CURSOR_WAIT] = RST_CURSOR_WAIT;
    model_st = seq_reset_state();
    plan_st = seq_reset_state();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset waits: idle tick with every field high, saturated cursor on row 1
    gap_mode = GAP_NONE;
    push_cmd(mk_cmd(MODE_TICK, 8'hFF, 1'b1, 16'hFFFF, 1'b1, 6'h3F));
    push_cmd(mk_cmd(MODE_CURSOR, 8'h00, 1'b0, 16'h0000, 1'b1, 6'h3F));
    tick_until_idle();

    // Short waits for the directed checks
    load_waits(16'd3, 16'd1, 16'd0, 16'd2, 16'd1);
    push_cmd(mk_cmd(MODE_WRITE, 8'hFF, 1'b1, 16'd0, 1'b0, 6'd0));
    tick_until_idle();
    push_cmd(mk_cmd(MODE_WRITE, 8'h00, 1'b0, 16'd1, 1'b0, 6'd0));
    push_ticks(2);
    push_cmd(mk_cmd(MODE_WRITE, 8'h5A, 1'b1, 16'd0, 1'b0, 6'd0));
    tick_until_idle();
    push_cmd(mk_cmd(MODE_WRITE, 8'hA5, 1'b1, 16'd3, 1'b0, 6'd0));
    push_ticks(1);
    push_cmd(mk_cmd(MODE_INIT, 8'h00, 1'b0, 16'd0, 1'b0, 6'd0));
    push_cmd(mk_cmd(MODE_CURSOR, 8'h00, 1'b0, 16'd0, 1'b1, 6'd5));
    tick_until_idle();
    push_cmd(mk_cmd(MODE_CURSOR, 8'h00, 1'b0, 16'd0, 1'b0, 6'd0));
    tick_until_idle();
    push_cmd(mk_cmd(MODE_CURSOR, 8'h00, 1'b0, 16'd0, 1'b1, 6'd39));
    tick_until_idle();
    push_cmd(mk_cmd(MODE_CURSOR, 8'h00, 1'b0, 16'd0, 1'b0, 6'd40));
    tick_until_idle();
    push_cmd(mk_cmd(MODE_INIT, 8'h00, 1'b0, 16'd0, 1'b0, 6'd0));
    tick_until_idle();

    // Change waits in the middle of an init sequence
    push_cmd(mk_cmd(MODE_INIT, 8'h00, 1'b0, 16'd0, 1'b0, 6'd0));
    push_ticks(6);
    load_waits(16'd3, 16'd1, 16'd2, 16'd0, 16'd1);
    tick_until_idle();

    // Random phases over several wait settings and idling patterns
    load_waits(16'd2, 16'd0, 16'd1, 16'd0, 16'd0);
    random_burst(GAP_NONE, 280, 4);
    load_random_waits(6);
    random_burst(GAP_SEND, 280, 6);
    load_random_waits(6);
    hold_arm = 1'b1;
    random_burst(GAP_RECV, 280, 6);
    load_waits(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    random_burst(GAP_BOTH, 280, 3);
    load_random_waits(9);
    random_burst(GAP_NONE, 280, 20);
    load_random_waits(6);
    random_burst(GAP_BOTH, 200, 8);

    // Largest waits: a long write that stays busy, with commands bounced off it
    load_waits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    gap_mode = GAP_SEND;
    push_cmd(mk_cmd(MODE_WRITE, 8'($urandom), 1'($urandom), 16'hFFFF, 1'b0, 6'd0));
    push_ticks(30);
    push_cmd(rand_cmd(MODE_INIT));
    push_cmd(rand_cmd(MODE_CURSOR));
    push_cmd(rand_cmd(MODE_WRITE));
    push_ticks(5);

    while (lcd_cmds_pending.size() != 0 || in_valid || pins_due.size() != 0) @(negedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (pins_due.size() != 0) mismatches++;
    $display("Run covered %0d beats in, %0d results out (%0d rejected commands).",
             beats_in, results_seen, rejects_seen);
    $display("Wait registers: %0d writes over %0d settings, all-zero and all-max included.",
             cfg_writes, settings_used);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatching or unexpected results", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
